// File: rtl/full_linear_convolution_defines.svh
// Assertion macros shared by the convolution RTL.
`ifndef FULL_LINEAR_CONVOLUTION_DEFINES_SVH
`define FULL_LINEAR_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FLC_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("flc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FLC_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("flc: next-cycle check failed");

`endif

// File: rtl/flc_pkg.sv
// Shared constants and types of the full linear convolution block.
package flc_pkg;

    localparam int MAX_TAPS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_TAPS);
    localparam int LEN_W       = 5;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int RES_BITS    = 36;

    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Control from the sequencer to the multiply-accumulate.
    typedef struct packed {
        logic clr;  // zero the accumulator
        logic vld;  // operands present this cycle
    } mac_ctrl_t;

endpackage

// File: rtl/flc_mac.sv
// Registered multiply followed by a 36-bit accumulator.
module flc_mac
    import flc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_BITS-1:0] tap,
    input  logic signed [SAMPLE_BITS-1:0] smp,
    output logic signed [RES_BITS-1:0] acc,
    output logic                       busy
);

    logic                     mul_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RES_BITS-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= ctrl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.vld)
        begin
            prod_reg <= tap * smp;
        end
        if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + RES_BITS'(prod_reg);
        end
    end

    assign acc  = acc_reg;
    assign busy = mul_vld_reg;

endmodule

// File: rtl/full_linear_convolution.sv
// Top level: full linear convolution of a sample stream with a stored kernel.
//
// channel  direction  handshake              words
// item     in         item_valid/item_stall  kind, tap_index, value, last
// res      out        res_valid/res_stall    result, run_end, signal_end
// cfg      in         cfg_valid/cfg_ready    cfg_data = kernel_length
//
// A tap word is written while the block stays idle. A sample word passes these
// steps before the next accept (len = taps in use): the accepting idle state, a
// ring write, len reads of the tap and ring memories through the shared
// multiply-accumulate, a drain, and a load of the result register.
// A last sample adds len-1 tail outputs, each repeating the steps from the ring write.
// Reset clears the tap and history valid bits, so no memory sweep is needed.
// A stall on res holds the sequencer only when a new result is ready to load.
module full_linear_convolution
    import flc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          kind,
    input  logic [3:0]                    tap_index,
    input  logic signed [SAMPLE_BITS-1:0] value,
    input  logic                          last,
    // results
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic signed [RES_BITS-1:0]    result,
    output logic                          run_end,
    output logic                          signal_end,
    // kernel_length register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [LEN_W-1:0]              cfg_data
);

`include "full_linear_convolution_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Memories: kernel taps and a ring of past samples (newest at wp_reg).
    logic signed [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] tap_rd_reg;
    logic signed [SAMPLE_BITS-1:0] hist_rd_reg;

    // Valid bits stand in for the zero reset of both memories.
    logic [MAX_TAPS-1:0] tap_vld_reg;
    logic [MAX_TAPS-1:0] hist_vld_reg;
    logic                tap_ok_reg;
    logic                hist_ok_reg;
    logic                rd_vld_reg;

    logic [LEN_W-1:0]              kernel_length_reg;
    logic [IDX_W-1:0]              wp_reg;
    logic [IDX_W-1:0]              j_reg;
    logic [IDX_W-1:0]              len_m1_reg;
    logic [IDX_W-1:0]              tail_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] cur_reg;

    logic                          res_valid_reg;
    logic signed [RES_BITS-1:0]    result_reg;
    logic                          run_end_reg;
    logic                          signal_end_reg;

    logic                          item_take;
    logic                          tap_we;
    logic                          out_free;
    logic                          res_load;
    logic [IDX_W-1:0]              rd_addr;
    logic [LEN_W-1:0]              len_sat;
    logic [IDX_W-1:0]              len_m1_w;
    mac_ctrl_t                     mac_ctrl;
    logic signed [SAMPLE_BITS-1:0] tap_op;
    logic signed [SAMPLE_BITS-1:0] smp_op;
    logic signed [RES_BITS-1:0]    mac_acc;
    logic                          mac_busy;

    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign tap_we     = item_take && (kind == KIND_TAP);
    assign out_free   = !res_valid_reg || !res_stall;
    assign res_load   = (state_reg == ST_DONE) && out_free;
    assign cfg_ready  = 1'b1;

    // tap j pairs with the sample j positions back from the newest one
    assign rd_addr = wp_reg - j_reg;

    // zero length means one tap, anything above the maximum saturates
    always_comb
    begin
        priority if (kernel_length_reg == '0)
        begin
            len_sat = LEN_W'(1);
        end
        else if (kernel_length_reg > LEN_W'(MAX_TAPS))
        begin
            len_sat = LEN_W'(MAX_TAPS);
        end
        else
        begin
            len_sat = kernel_length_reg;
        end
    end
    assign len_m1_w = IDX_W'(len_sat - LEN_W'(1));

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_index[IDX_W-1:0]] <= value;
        end
        if (state_reg == ST_RUN)
        begin
            tap_rd_reg <= tap_mem[j_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            ring_mem[wp_reg] <= cur_reg;
        end
        if (state_reg == ST_RUN)
        begin
            hist_rd_reg <= ring_mem[rd_addr];
        end
    end

    // unwritten entries read as zero
    assign tap_op = tap_ok_reg  ? tap_rd_reg  : '0;
    assign smp_op = hist_ok_reg ? hist_rd_reg : '0;

    assign mac_ctrl.clr = (state_reg == ST_WRITE);
    assign mac_ctrl.vld = rd_vld_reg;

    flc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .tap   (tap_op),
        .smp   (smp_op),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            tap_vld_reg       <= '0;
            hist_vld_reg      <= '0;
            tap_ok_reg        <= 1'b0;
            hist_ok_reg       <= 1'b0;
            rd_vld_reg        <= 1'b0;
            kernel_length_reg <= LEN_W'(1);
            wp_reg            <= '0;
            j_reg             <= '0;
            len_m1_reg        <= '0;
            tail_reg          <= '0;
            last_reg          <= 1'b0;
            cur_reg           <= '0;
            res_valid_reg     <= 1'b0;
            result_reg        <= '0;
            run_end_reg       <= 1'b0;
            signal_end_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                kernel_length_reg <= cfg_data;
            end
            if (!res_stall && !res_load)
            begin
                res_valid_reg <= 1'b0;
            end
            rd_vld_reg <= (state_reg == ST_RUN);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (tap_we)
                    begin
                        tap_vld_reg[tap_index[IDX_W-1:0]] <= 1'b1;
                    end
                    else if (item_take)
                    begin
                        cur_reg    <= value;
                        last_reg   <= last;
                        len_m1_reg <= len_m1_w;
                        tail_reg   <= last ? len_m1_w : '0;
                        state_reg  <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    // newest sample lands in the ring; reads start next cycle
                    hist_vld_reg[wp_reg] <= 1'b1;
                    j_reg                <= '0;
                    state_reg            <= ST_RUN;
                end
                ST_RUN:
                begin
                    tap_ok_reg  <= tap_vld_reg[j_reg];
                    hist_ok_reg <= hist_vld_reg[rd_addr];
                    if (j_reg == len_m1_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_vld_reg && !mac_busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        result_reg     <= mac_acc;
                        run_end_reg    <= (tail_reg == '0);
                        signal_end_reg <= last_reg && (tail_reg == '0);
                        wp_reg         <= wp_reg + IDX_W'(1);
                        if (tail_reg != '0)
                        begin
                            // tail output: shift a zero in
                            tail_reg  <= tail_reg - IDX_W'(1);
                            cur_reg   <= '0;
                            state_reg <= ST_WRITE;
                        end
                        else
                        begin
                            if (last_reg)
                            begin
                                hist_vld_reg <= '0;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign result     = result_reg;
    assign run_end    = run_end_reg;
    assign signal_end = signal_end_reg;

    `FLC_ASSERT_IMP(a_sig_end_has_run_end, res_valid && signal_end, run_end)
    `FLC_ASSERT_IMP(a_j_in_range, state_reg == ST_RUN, j_reg <= len_m1_reg)
    `FLC_ASSERT_NXT(a_history_cleared,
        state_reg == ST_DONE && out_free && tail_reg == '0 && last_reg,
        hist_vld_reg == '0)
    `FLC_ASSERT_NXT(a_tail_continues,
        state_reg == ST_DONE && out_free && tail_reg != '0,
        state_reg == ST_WRITE && cur_reg == '0)
    `FLC_ASSERT_IMP(a_mac_idle_on_clear, state_reg == ST_WRITE, !mac_busy && !rd_vld_reg)

endmodule

// File: test/full_linear_convolution_tb.sv
// Self-checking testbench for the full linear convolution block.
module full_linear_convolution_tb
    import flc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Long enough for a full tail with taps at maximum and the receiver's
    // long hold-off on top.
    localparam int QUIET_LIMIT   = 4000;
    // A word that yields no result may still be in the block when the last
    // expected result arrives; this also covers the watch for stray results.
    localparam int DRAIN_CYCLES  = 2 * (MAX_TAPS + 4);
    localparam int HOLDOFF_LEN   = 300;
    localparam int RANDOM_WORDS  = 320;
    localparam int MAX_REPORTS   = 200;

    typedef struct {
        logic signed [RES_BITS-1:0] result;
        logic                       run_end;
        logic                       signal_end;
    } conv_out_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_stall;
    logic                          kind = KIND_TAP;
    logic [3:0]                    tap_index = '0;
    logic signed [SAMPLE_BITS-1:0] value = '0;
    logic                          last = 1'b0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    logic signed [RES_BITS-1:0]    result;
    logic                          run_end;
    logic                          signal_end;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [LEN_W-1:0]              cfg_data = '0;

    // Expected outputs, oldest first.
    conv_out_t pending_outputs[$];

    // Shadow copy of the block's state.
    logic signed [SAMPLE_BITS-1:0] kernel_model [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] history_model [MAX_TAPS-1];
    logic [LEN_W-1:0]              length_model;

    int errors = 0;
    int reports = 0;
    int quiet_cycles = 0;
    // Idling switches for each side; cleared for stretches at full rate.
    bit item_gaps_on = 1'b1;
    bit res_gaps_on = 1'b1;
    // Set by a test to make the receiver hold off for that many cycles.
    int holdoff_cycles = 0;

    always #6 clk = ~clk;

    full_linear_convolution uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .kind       (kind),
        .tap_index  (tap_index),
        .value      (value),
        .last       (last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .result     (result),
        .run_end    (run_end),
        .signal_end (signal_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Length zero behaves as one tap; anything past MAX_TAPS saturates.
    function automatic int unsigned taps_in_use();
        if (length_model == 0)
            return 1;
        if (length_model > MAX_TAPS)
            return MAX_TAPS;
        return length_model;
    endfunction

    // One output with cur as the newest sample; cur then enters the history.
    function automatic logic signed [RES_BITS-1:0] convolve_step(
        input logic signed [SAMPLE_BITS-1:0] cur,
        input int unsigned                   n_taps
    );
        longint acc;
        longint hi;
        int     j;
        hi = (longint'(1) <<< (RES_BITS - 1)) - 1;
        acc = longint'(kernel_model[0]) * longint'(cur);
        for (j = 1; j < n_taps; j++)
            acc += longint'(kernel_model[j]) * longint'(history_model[j-1]);
        for (j = MAX_TAPS - 2; j > 0; j--)
            history_model[j] = history_model[j-1];
        history_model[0] = cur;
        // Cannot trigger at these widths; the block itself does not saturate.
        if (acc > hi)
            acc = hi;
        if (acc < -hi - 1)
            acc = -hi - 1;
        return acc[RES_BITS-1:0];
    endfunction

    function automatic void queue_output(
        input logic signed [RES_BITS-1:0] r,
        input logic                       r_end,
        input logic                       s_end
    );
        conv_out_t o;
        o.result = r;
        o.run_end = r_end;
        o.signal_end = s_end;
        pending_outputs.push_back(o);
    endfunction

    function automatic void predict_word(
        input logic                          k,
        input logic [3:0]                    idx,
        input logic signed [SAMPLE_BITS-1:0] v,
        input logic                          is_last
    );
        int unsigned n_taps;
        int unsigned left;
        // Tap words write the kernel only; their last flag means nothing.
        if (k == KIND_TAP)
        begin
            kernel_model[idx] = v;
            return;
        end
        n_taps = taps_in_use();
        if (!is_last)
        begin
            queue_output(convolve_step(v, n_taps), 1'b1, 1'b0);
            return;
        end
        // Final sample: its own output, then the tail with zeros shifted in.
        left = n_taps - 1;
        queue_output(convolve_step(v, n_taps), left == 0, left == 0);
        while (left > 0)
        begin
            left--;
            queue_output(convolve_step('0, n_taps), left == 0, left == 0);
        end
        foreach (history_model[j])
            history_model[j] = '0;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Returns at the edge that accepts the word, with item_valid still high,
    // so back-to-back calls keep the channel busy. Anything else that lets
    // time pass must drop valid first (release_items).
    task automatic send_word(
        input logic                          k,
        input logic [3:0]                    idx,
        input logic signed [SAMPLE_BITS-1:0] v,
        input logic                          is_last
    );
        int gap;
        gap = item_gaps_on ? $urandom_range(0, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind <= k;
        tap_index <= idx;
        value <= v;
        last <= is_last;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_word(k, idx, v, is_last);
    endtask

    task automatic release_items();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    // Block is idle once every expected output is in and any trailing tap
    // word has had time to settle.
    task automatic wait_idle();
        release_items();
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        wait_idle();
        cfg_data <= len;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        length_model = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Extremes get a fair share, the rest is spread over the full range.
    function automatic logic signed [SAMPLE_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Receiver: a random stall before every result word while res gaps are on, or the long
    // hold-off when a test asks for one.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                n = holdoff_cycles;
                holdoff_cycles = 0;
            end
            else
            begin
                n = res_gaps_on ? $urandom_range(0, 16) : 0;
            end
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    // ---------------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        conv_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: unexpected result word: expected none, got result=%0d",
                             $realtime, result);
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result !== want.result)
                begin
                    errors++;
                    if (reports++ < MAX_REPORTS)
                        $display("%0t: result: expected %0d, got %0d",
                                 $realtime, want.result, result);
                end
                if (run_end !== want.run_end)
                begin
                    errors++;
                    if (reports++ < MAX_REPORTS)
                        $display("%0t: run_end: expected %0b, got %0b",
                                 $realtime, want.run_end, run_end);
                end
                if (signal_end !== want.signal_end)
                begin
                    errors++;
                    if (reports++ < MAX_REPORTS)
                        $display("%0t: signal_end: expected %0b, got %0b",
                                 $realtime, want.signal_end, signal_end);
                end
            end
        end
    end

    // Watchdog: any accepted word on any channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Out of reset: one tap, all taps zero.
    task automatic test_reset_state();
        send_word(KIND_SAMPLE, 4'd0, 16'sd12345, 1'b0);
        send_word(KIND_SAMPLE, 4'd15, -16'sd1, 1'b1);
    endtask

    // Full-scale taps and samples, an ignored last flag on a tap word,
    // and a kernel change in the middle of a signal.
    task automatic test_extremes();
        write_length(5'd2);
        send_word(KIND_TAP, 4'd0, 16'sh7FFF, 1'b0);
        send_word(KIND_TAP, 4'd1, 16'sh8000, 1'b1);
        send_word(KIND_SAMPLE, 4'd0, 16'sh8000, 1'b0);
        send_word(KIND_SAMPLE, 4'd0, 16'sh7FFF, 1'b0);
        send_word(KIND_SAMPLE, 4'd0, -16'sd1, 1'b0);
        send_word(KIND_TAP, 4'd1, -16'sd1, 1'b0);
        send_word(KIND_SAMPLE, 4'd0, 16'sd0, 1'b1);
    endtask

    // Longest tail, and the out-of-range lengths (zero, just above and far
    // above the tap count).
    task automatic test_length_limits();
        write_length(5'd16);
        send_word(KIND_TAP, 4'd15, 16'sh8000, 1'b0);
        send_word(KIND_SAMPLE, 4'd0, 16'sh8000, 1'b1);
        write_length(5'd0);
        send_word(KIND_SAMPLE, 4'd0, 16'sd100, 1'b1);
        write_length(5'd31);
        send_word(KIND_SAMPLE, 4'd0, -16'sd1, 1'b1);
        write_length(5'd17);
        send_word(KIND_SAMPLE, 4'd0, 16'sd5, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering samples, so the
    // block backs up and stalls its input.
    task automatic test_backpressure();
        int i;
        write_length(5'd4);
        for (i = 0; i < 4; i++)
            send_word(KIND_TAP, 4'(i), rand_word(), 1'b0);
        holdoff_cycles = HOLDOFF_LEN;
        item_gaps_on = 1'b0;
        for (i = 0; i < 12; i++)
            send_word(KIND_SAMPLE, 4'($urandom), rand_word(), i == 11);
        item_gaps_on = 1'b1;
    endtask

    // Whole signals with random kernels and lengths; stray tap writes land
    // mid-signal now and then.
    task automatic test_random_signals();
        int               sent;
        int               n_samples;
        int               i;
        logic [LEN_W-1:0] len;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0: len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
                1: len = 5'd16;
                default: len = 5'($urandom_range(1, 16));
            endcase
            write_length(len);
            item_gaps_on = ($urandom_range(0, 3) != 0);
            res_gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 4))
            begin
                send_word(KIND_TAP, 4'($urandom), rand_word(), 1'($urandom));
                sent++;
            end
            n_samples = $urandom_range(1, 10);
            for (i = 1; i <= n_samples; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(KIND_TAP, 4'($urandom), rand_word(), 1'($urandom));
                    sent++;
                end
                send_word(KIND_SAMPLE, 4'($urandom), rand_word(), i == n_samples);
                sent++;
            end
        end
        item_gaps_on = 1'b1;
        res_gaps_on = 1'b1;
    endtask

    initial
    begin
        foreach (kernel_model[j])
            kernel_model[j] = '0;
        foreach (history_model[j])
            history_model[j] = '0;
        length_model = 5'd1;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extremes();
        test_length_limits();
        test_backpressure();
        test_random_signals();

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
